/* hw/rtl/akct_pkg.sv */
// shared types and constants of the address keyed command table
`default_nettype none

package akct_pkg;

  // fixed port widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ADDRESS_W = 48;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned STATUS_W  = 3;

  // hash arithmetic
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned HASH_MULT = 31;

  // remainder unit: reciprocal multiply, then multiply back and subtract
  localparam int unsigned MOD_STEPS = 2;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  // request operations; the unused code behaves as a lookup
  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_DELETED   = 3'd5
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_step;
    logic hash_step;
    logic mod_step;
    logic vrd;
    logic vcap;
    logic erd;
    logic cmp;
    logic way_inc;
    logic commit;
    logic push;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic mod_last;
    logic hit_now;
    logic way_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/akct_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module akct_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AW-1:0]                 waddr_i,
  input  wire logic [WIDTH-1:0]              wdata_i,
  input  wire logic                          re_i,
  input  wire logic [AW-1:0]                 raddr_i,
  output logic      [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/akct_ctrl.sv */
// request sequencer of the address keyed command table
`default_nettype none

module akct_ctrl
  import akct_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_HASH   = 10'b00_0000_0100,
    S_MOD    = 10'b00_0000_1000,
    S_VRD    = 10'b00_0001_0000,
    S_VCAP   = 10'b00_0010_0000,
    S_ERD    = 10'b00_0100_0000,
    S_ECMP   = 10'b00_1000_0000,
    S_COMMIT = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        cmd_o.vrd = 1'b1;
        state_d   = S_VCAP;
      end
      S_VCAP: begin
        cmd_o.vcap = 1'b1;
        state_d    = S_ERD;
      end
      S_ERD: begin
        cmd_o.erd = 1'b1;
        state_d   = S_ECMP;
      end
      S_ECMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.hit_now || sts_i.way_last) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.way_inc = 1'b1;
          state_d       = S_ERD;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/akct_dp.sv */
// hash, bucket probe, table memories and result register
`default_nettype none

module akct_dp
  import akct_pkg::*;
#(
  parameter int unsigned BUCKETS       = 16,
  parameter int unsigned WAYS          = 4,
  parameter int unsigned ADDRESS_BYTES = 6,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  output dp_sts_t                   sts_o,
  input  wire logic [CMD_W-1:0]     cmd_word_i,
  input  wire logic [ADDRESS_W-1:0] address_i,
  input  wire logic [VALUE_W-1:0]   command_value_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [VALUE_W-1:0]        stored_value_o
);

  localparam int unsigned BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENTRIES = BUCKETS * WAYS;
  localparam int unsigned ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned BYTE_W  = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
  localparam int unsigned KEY_W   = (ADDRESS_BYTES * 8 < ADDRESS_W) ? ADDRESS_BYTES * 8
                                                                    : ADDRESS_W;
  localparam int unsigned VAL_W   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned ENTRY_W = KEY_W + VAL_W;

  // reciprocal of the bucket count, rounded up, exact for any 32-bit hash
  localparam int unsigned RCP_SH = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
  localparam int unsigned RCP_W  = HASH_W + 1;
  localparam int unsigned PROD_W = HASH_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << (HASH_W + RCP_SH)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  // request word
  cmd_e             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // hash and remainder
  logic [KEY_W-1:0]     hsh_key_q;
  logic [HASH_W-1:0]    hash_q;
  logic [BYTE_W-1:0]    byte_cnt_q;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [HASH_W-1:0]    quo_q, quo_d;
  logic [PROD_W-1:0]    rcp_prod;
  logic [HASH_W-1:0]    quo_mul;
  logic [BKT_W-1:0]     rem_q, rem_d;

  // probe
  logic [WAY_W-1:0] way_q;
  logic [WAYS-1:0]  vrow_q;
  logic             hit_q;
  logic [VAL_W-1:0] hit_val_q;

  // clearing pass and result
  logic [BKT_W-1:0] clr_q;
  status_e          res_status_q, res_status_d;
  logic [VAL_W-1:0] res_value_q, res_value_d;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [VAL_W-1:0] out_value_q;

  // memory ports
  logic               vld_we;
  logic [BKT_W-1:0]   vld_waddr;
  logic [WAYS-1:0]    vld_wdata, vld_rdata, vrow_new;
  logic               vrow_we;
  logic               ent_we;
  logic [ENT_W-1:0]   ent_base, ent_waddr, ent_raddr;
  logic [ENTRY_W-1:0] ent_rdata;
  logic [KEY_W-1:0]   ent_key;
  logic [VAL_W-1:0]   ent_val;

  // free way search and write way
  logic             free_any;
  logic [WAY_W-1:0] free_way, wr_way;

  // one hash step: h = byte + 31*h, 32-bit wrap
  logic [HASH_W-1:0] hash_next;
  assign hash_next = HASH_W'(hsh_key_q[7:0]) + HASH_W'(hash_q * HASH_W'(HASH_MULT));

  // remainder, first step: quotient by reciprocal multiply
  assign rcp_prod = PROD_W'(hash_q) * PROD_W'(RCP);
  assign quo_d    = HASH_W'(rcp_prod >> (HASH_W + RCP_SH));

  // remainder, second step: multiply back and subtract
  assign quo_mul = quo_q * HASH_W'(BUCKETS);
  assign rem_d   = BKT_W'(hash_q - quo_mul);

  // entry memory split
  assign ent_key = ent_rdata[ENTRY_W-1:VAL_W];
  assign ent_val = ent_rdata[VAL_W-1:0];

  // lowest free way of the bucket
  always_comb begin
    free_any = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow_q[w]) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  assign wr_way    = hit_q ? way_q : free_way;
  assign ent_base  = ENT_W'(rem_q) * ENT_W'(WAYS);
  assign ent_raddr = ent_base + ENT_W'(way_q);
  assign ent_waddr = ent_base + ENT_W'(wr_way);

  // commit decision
  always_comb begin
    res_status_d = ST_NOT_FOUND;
    res_value_d  = '0;
    ent_we       = 1'b0;
    vrow_we      = 1'b0;
    vrow_new     = vrow_q;
    case (cmd_q)
      CMD_ADD: begin
        if (hit_q) begin
          ent_we       = 1'b1;
          res_status_d = ST_UPDATED;
          res_value_d  = val_q;
        end else if (free_any) begin
          ent_we       = 1'b1;
          vrow_we      = 1'b1;
          vrow_new     = vrow_q | (WAYS'(1) << free_way);
          res_status_d = ST_ADDED;
          res_value_d  = val_q;
        end else begin
          res_status_d = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (hit_q) begin
          vrow_we      = 1'b1;
          vrow_new     = vrow_q & ~(WAYS'(1) << way_q);
          res_status_d = ST_DELETED;
          res_value_d  = hit_val_q;
        end
      end
      default: begin
        if (hit_q) begin
          res_status_d = ST_FOUND;
          res_value_d  = hit_val_q;
        end
      end
    endcase
  end

  // valid memory write: clearing pass or commit
  always_comb begin
    if (cmd_i.clr_step) begin
      vld_we    = 1'b1;
      vld_waddr = clr_q;
      vld_wdata = '0;
    end else begin
      vld_we    = cmd_i.commit && vrow_we;
      vld_waddr = rem_q;
      vld_wdata = vrow_new;
    end
  end

  // one row of valid marks per bucket
  akct_ram #(
    .WIDTH (WAYS),
    .DEPTH (BUCKETS)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .re_i    (cmd_i.vrd),
    .raddr_i (rem_q),
    .rdata_o (vld_rdata)
  );

  // address and command word of each entry
  akct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && ent_we),
    .waddr_i (ent_waddr),
    .wdata_i ({key_q, val_q}),
    .re_i    (cmd_i.erd),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      byte_cnt_q  <= '0;
      mod_cnt_q   <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + BKT_W'(1);
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        byte_cnt_q <= '0;
        mod_cnt_q  <= '0;
        way_q      <= '0;
        hit_q      <= 1'b0;
      end else begin
        if (cmd_i.hash_step) begin
          byte_cnt_q <= byte_cnt_q + BYTE_W'(1);
        end
        if (cmd_i.mod_step) begin
          mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
        end
        if (cmd_i.way_inc) begin
          way_q <= way_q + WAY_W'(1);
        end
        if (cmd_i.cmp) begin
          hit_q <= sts_o.hit_now;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= cmd_e'(cmd_word_i);
      key_q     <= address_i[KEY_W-1:0];
      val_q     <= command_value_i[VAL_W-1:0];
      hsh_key_q <= address_i[KEY_W-1:0];
      hash_q    <= '0;
      rem_q     <= '0;
    end
    if (cmd_i.hash_step) begin
      hash_q    <= hash_next;
      hsh_key_q <= hsh_key_q >> 8;
    end
    if (cmd_i.mod_step) begin
      if (mod_cnt_q == '0) begin
        quo_q <= quo_d;
      end else begin
        rem_q <= rem_d;
      end
    end
    if (cmd_i.vcap) begin
      vrow_q <= vld_rdata;
    end
    if (cmd_i.cmp) begin
      hit_val_q <= ent_val;
    end
    if (cmd_i.commit) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
    end
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  // status to the controller
  assign sts_o.clr_last  = (clr_q == BKT_W'(BUCKETS - 1));
  assign sts_o.hash_last = (byte_cnt_q == BYTE_W'(ADDRESS_BYTES - 1));
  assign sts_o.mod_last  = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
  assign sts_o.hit_now   = vrow_q[way_q] && (ent_key == key_q);
  assign sts_o.way_last  = (way_q == WAY_W'(WAYS - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // result word
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign stored_value_o = VALUE_W'(out_value_q);

endmodule

`default_nettype wire

/* hw/rtl/address_keyed_command_table_core.sv */
// top level of the address keyed command table
//
// Maps a device address to a command word in a table of BUCKETS buckets of
// WAYS ways. The input channel (in_valid_i / in_stall_o) carries one request
// word: cmd_i (lookup, add or update, delete), address_i and command_value_i.
// The output channel (out_valid_o / out_stall_i) returns one result word per
// request: status_o and stored_value_o, in request order.
// A word moves at a clock edge with valid high and stall low.
// After acceptance a request passes the byte-serial hash, the remainder unit
// (reciprocal multiply, then multiply back and subtract), the read of the
// bucket's valid row and the probe, which reads the single read port of the
// entry memory one way at a time and stops at the first address match or at
// the last way; then the result is committed and handed to the output
// register. The next request is taken only once the result is handed over,
// so a request is not accepted while an earlier one is still in progress.
// The output register holds a result while the receiver stalls; a request
// may be accepted meanwhile, and its result waits until the register frees.
// After reset the valid marks are cleared, one bucket row a cycle, with
// in_stall_o high.
`default_nettype none

module address_keyed_command_table_core
  import akct_pkg::*;
#(
  parameter int unsigned BUCKETS       = 16,
  parameter int unsigned WAYS          = 4,
  parameter int unsigned ADDRESS_BYTES = 6,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [CMD_W-1:0]     cmd_i,
  input  wire logic [ADDRESS_W-1:0] address_i,
  input  wire logic [VALUE_W-1:0]   command_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [VALUE_W-1:0]        stored_value_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer
  akct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // datapath with table memories
  akct_dp #(
    .BUCKETS       (BUCKETS),
    .WAYS          (WAYS),
    .ADDRESS_BYTES (ADDRESS_BYTES),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .cmd_word_i      (cmd_i),
    .address_i       (address_i),
    .command_value_i (command_value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .stored_value_o  (stored_value_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// testbench for the address keyed command table: scoreboard model, drivers and checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import akct_pkg::*;

  localparam int unsigned N_BUCKETS  = 16;
  localparam int unsigned N_WAYS     = 4;
  localparam int unsigned ADDR_BYTES = 6;
  localparam int unsigned N_ENTRIES  = N_BUCKETS * N_WAYS;

  // the unused operation code, answered like a lookup
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // one result word as the table should answer it
  typedef struct packed {
    status_e              status;
    logic [VALUE_W-1:0]   value;
  } reply_t;

  // shadow of the table; predicts one reply word per accepted request word
  class command_table_model;
    bit                   entry_valid [N_ENTRIES];
    logic [ADDRESS_W-1:0] entry_addr  [N_ENTRIES];
    logic [VALUE_W-1:0]   entry_word  [N_ENTRIES];
    reply_t               pending_replies [$];
    int unsigned          fail_count;

    function new();
      fail_count = 0;
      foreach (entry_valid[i]) entry_valid[i] = 1'b0;
    endfunction

    // multiplier-31 hash over the address bytes, low byte first
    static function int unsigned bucket_of(logic [ADDRESS_W-1:0] a);
      int unsigned h;
      h = 0;
      for (int i = 0; i < ADDR_BYTES; i++) h = a[8*i +: 8] + HASH_MULT * h;
      return h % N_BUCKETS;
    endfunction

    function void note_request(logic [CMD_W-1:0] op, logic [ADDRESS_W-1:0] a,
                               logic [VALUE_W-1:0] v);
      int unsigned base;
      int          hit;
      reply_t      r;
      base = bucket_of(a) * N_WAYS;
      hit = -1;
      for (int w = 0; w < N_WAYS; w++) begin
        if (hit < 0 && entry_valid[base+w] && entry_addr[base+w] == a) hit = base + w;
      end
      r.status = ST_NOT_FOUND;
      r.value  = '0;
      case (op)
        CMD_ADD: begin
          if (hit >= 0) begin
            entry_word[hit] = v;
            r.status = ST_UPDATED;
            r.value  = v;
          end else begin
            // lowest free way, or full
            r.status = ST_FULL;
            for (int w = 0; w < N_WAYS; w++) begin
              if (r.status == ST_FULL && !entry_valid[base+w]) begin
                entry_valid[base+w] = 1'b1;
                entry_addr[base+w]  = a;
                entry_word[base+w]  = v;
                r.status = ST_ADDED;
                r.value  = v;
              end
            end
          end
        end
        CMD_DELETE: begin
          if (hit >= 0) begin
            r.value = entry_word[hit];
            entry_valid[hit] = 1'b0;
            r.status = ST_DELETED;
          end
        end
        default: begin
          if (hit >= 0) begin
            r.value  = entry_word[hit];
            r.status = ST_FOUND;
          end
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] v);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result word: status %0d value %h", $time, st, v);
        fail_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (st !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, exp_r.status, st);
          fail_count++;
        end
        if (v !== exp_r.value) begin
          $display("%0t: stored_value mismatch: expected %h actual %h",
                   $time, exp_r.value, v);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     cmd = CMD_FIND;
  logic [ADDRESS_W-1:0] address = '0;
  logic [VALUE_W-1:0]   command_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [VALUE_W-1:0]   stored_value;

  command_table_model predicted_table = new();

  address_keyed_command_table_core #(
    .BUCKETS      (N_BUCKETS),
    .WAYS         (N_WAYS),
    .ADDRESS_BYTES(ADDR_BYTES),
    .VALUE_BITS   (VALUE_W)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .address_i      (address),
    .command_value_i(command_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .stored_value_o (stored_value)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("** address_keyed_command_table_core: FAILED **");
    $finish;
  end

  function automatic logic [ADDRESS_W-1:0] fresh_address();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[ADDRESS_W-1:0];
  endfunction

  function automatic logic [ADDRESS_W-1:0] address_in_bucket(int unsigned b);
    logic [ADDRESS_W-1:0] a;
    a = fresh_address();
    while (command_table_model::bucket_of(a) != b) a = fresh_address();
    return a;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // offer one request word, with an optional idle gap first; returns at acceptance
  task automatic send_request(logic [CMD_W-1:0] op, logic [ADDRESS_W-1:0] a,
                              logic [VALUE_W-1:0] v, bit may_idle);
    int unsigned gap;
    gap = 0;
    if (may_idle && $urandom_range(99) < 18) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= op;
    address       <= a;
    command_value <= v;
    do @(posedge clk); while (in_stall);
    predicted_table.note_request(op, a, v);
  endtask

  // receiver: random stalls, one long hold-off, and a stretch without stalls
  initial begin
    int unsigned results;
    int unsigned hold_left;
    bit          held;
    results = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        predicted_table.check_result(status, stored_value);
        results++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && results >= 60) begin
        held = 1'b1;
        hold_left = 300;
        out_stall <= 1'b1;
      end else if (results >= 300 && results < 400) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 18);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [ADDRESS_W-1:0] grp [5];
    logic [ADDRESS_W-1:0] pool [$];
    logic [ADDRESS_W-1:0] a;
    logic [CMD_W-1:0]     op;
    int unsigned          b;
    int unsigned          r;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // five addresses sharing one bucket, to fill it and overflow it
    b = $urandom_range(N_BUCKETS - 1);
    foreach (grp[i]) grp[i] = address_in_bucket(b);

    // directed: empty table, add, update, full bucket, delete, spare code, extremes
    send_request(CMD_FIND,   grp[0], 32'h1234_5678, 1'b1);
    send_request(CMD_DELETE, grp[0], '0, 1'b1);
    send_request(CMD_ADD,    grp[0], '0, 1'b1);
    send_request(CMD_ADD,    grp[0], '1, 1'b1);
    send_request(CMD_FIND,   grp[0], '0, 1'b1);
    send_request(CMD_ADD,    grp[1], $urandom, 1'b1);
    send_request(CMD_ADD,    grp[2], $urandom, 1'b1);
    send_request(CMD_ADD,    grp[3], $urandom, 1'b1);
    send_request(CMD_ADD,    grp[4], $urandom, 1'b1);
    send_request(CMD_SPARE,  grp[2], '1, 1'b1);
    send_request(CMD_DELETE, grp[1], '0, 1'b1);
    send_request(CMD_ADD,    grp[4], 32'h8000_0001, 1'b1);
    send_request(CMD_FIND,   grp[4], '0, 1'b1);
    send_request(CMD_ADD,    '0, $urandom, 1'b1);
    send_request(CMD_ADD,    '1, '1, 1'b1);
    send_request(CMD_FIND,   '0, '0, 1'b1);
    send_request(CMD_DELETE, '1, '0, 1'b1);
    send_request(CMD_FIND,   '1, '0, 1'b1);
    send_request(CMD_DELETE, grp[0], '0, 1'b1);
    send_request(CMD_SPARE,  grp[1], '0, 1'b1);

    // address pool: a few crowded buckets plus scattered addresses
    for (int k = 0; k < 3; k++) begin
      b = $urandom_range(N_BUCKETS - 1);
      for (int j = 0; j < 6; j++) pool.push_back(address_in_bucket(b));
    end
    for (int k = 0; k < 14; k++) pool.push_back(fresh_address());

    // random mix, mostly on pooled addresses so hits, updates and full buckets occur
    for (int n = 0; n < 500; n++) begin
      r = $urandom_range(99);
      if (r < 40) op = CMD_ADD;
      else if (r < 70) op = CMD_FIND;
      else if (r < 95) op = CMD_DELETE;
      else op = CMD_SPARE;
      if ($urandom_range(99) < 80) a = pool[$urandom_range(pool.size() - 1)];
      else a = fresh_address();
      send_request(op, a, random_value(), !(n >= 300 && n < 400));
    end
    in_valid <= 1'b0;

    // drain, then allow for any stray word
    while (predicted_table.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (predicted_table.fail_count == 0) begin
      $display("** address_keyed_command_table_core: PASSED **");
    end else begin
      $display("** address_keyed_command_table_core: FAILED **");
    end
    $finish;
  end

endmodule
